// ===== src/ccsl_pkg.sv =====
// Shared types and constants for the cyclic common substring length block.
`default_nettype none
package ccsl_pkg;

   localparam int CH_W = 8;
   localparam int OUT_W = 11;
   localparam int MIN_STRINGS = 2;

   // Register indexes of the configuration port.
   localparam int REG_STRING_COUNT = 0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_LOAD,
      ST_STREAM,
      ST_DRAIN,
      ST_UPDATE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   // Column data handed from one cell to the next.
   typedef struct packed {
      logic            valid;
      logic            first;
      logic [CH_W-1:0] b;
   } link_type;

   typedef struct packed {
      logic busy;
      logic done;
   } stat_type;

endpackage
`default_nettype wire

// ===== src/ccsl_cell.sv =====
// One dynamic programming cell: owns one row of string 0 and scores a column per cycle.
`default_nettype none
module ccsl_cell import ccsl_pkg::*; #(
   parameter int VW = 11
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            shift,
   input  wire logic [CH_W-1:0] a_in,
   input  wire logic            act_in,
   output logic [CH_W-1:0]      a_out,
   output logic                 act_out,
   input  wire link_type        lin,
   input  wire logic [VW-1:0]   vin,
   output link_type             lout,
   output logic [VW-1:0]        vout,
   output logic [VW-1:0]        rowmax
);

   logic [CH_W-1:0] a_ff;
   logic            act_ff;
   logic [VW-1:0]   hold_ff;
   link_type        link_ff;
   logic [VW-1:0]   val_ff;
   logic [VW-1:0]   rm_ff;
   logic [VW-1:0]   val_in;
   logic [VW-1:0]   rm_in;

   always_comb begin
      val_in = '0;
      if (lin.b == a_ff) begin
         val_in = lin.first ? VW'(1) : hold_ff + VW'(1);
      end
      rm_in = rm_ff;
      if (lin.valid) begin
         if (lin.first || val_in > rm_ff) begin
            rm_in = val_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= lin.valid;
      end
      link_ff.first <= lin.first;
      link_ff.b     <= lin.b;
      val_ff        <= val_in;
      rm_ff         <= rm_in;
      if (lin.valid) begin
         hold_ff <= vin;
      end
      if (shift) begin
         a_ff   <= a_in;
         act_ff <= act_in;
      end
   end

   assign a_out   = a_ff;
   assign act_out = act_ff;
   assign lout    = link_ff;
   assign vout    = val_ff;
   assign rowmax  = rm_ff;

endmodule
`default_nettype wire

// ===== src/ccsl_engine.sv =====
// Compute engine: character store, row memories, sequencer and the chain of cells.
`default_nettype none
module ccsl_engine import ccsl_pkg::*; #(
   parameter int MAX_STRINGS = 10,
   parameter int NCELLS      = 8,
   parameter int SW          = 4,
   parameter int PW          = 10,
   parameter int LENW        = 11,
   parameter int DW          = 11,
   parameter int CNTW        = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [CNTW-1:0] count,
   input  wire logic [LENW-1:0] lengths [MAX_STRINGS],
   input  wire logic            cw_en,
   input  wire logic [SW+PW-1:0] cw_addr,
   input  wire logic [CH_W-1:0] cw_data,
   input  wire logic            out_free,
   output stat_type             stat,
   output logic [DW-1:0]        result
);

   localparam int CTW0 = DW + 1;
   localparam int CTW1 = $clog2(NCELLS + 1);
   localparam int CTW  = (CTW0 > CTW1) ? CTW0 : CTW1;
   localparam int CIW  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
   localparam int CAW  = $clog2(NCELLS + 1);

   logic [CH_W-1:0] char_mem [1 << (SW + PW)];
   logic [DW-1:0]   prev_mem [1 << DW];
   logic [DW-1:0]   best_mem [1 << DW];
   logic [DW-1:0]   min_mem  [1 << (DW + 1)];

   state_type       state_ff, state_in;
   logic [SW-1:0]   k_ff, k_in;
   logic            d1_ff, d1_in, d2_ff, d2_in;
   logic [CTW-1:0]  i0_ff, i0_in;
   logic [CTW-1:0]  cnt_ff, cnt_in;
   logic [CTW-1:0]  wq_ff, wq_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic            ph_ff, ph_in;
   logic [DW-1:0]   res_ff, res_in;
   logic            load_vld_ff, load_vld_in, load_act_ff, load_act_in;
   logic            strm_vld_ff, strm_vld_in, strm_first_ff, strm_first_in;
   logic            sw_vld_ff, sw_vld_in;
   logic [CH_W-1:0] char_rd_ff;
   logic [DW-1:0]   prev_rd_ff, best_rd_ff, min_rd_ff;

   logic [SW+PW-1:0] char_ra;
   logic [DW-1:0]    prev_ra;
   logic [DW-1:0]    upd_i;
   logic [DW:0]      min_ra;
   logic             bw_en, mw_en;
   logic [DW-1:0]    nb, nm, rm_sel;
   logic             act_sel;

   logic [LENW-1:0] l1, lk;
   logic [CTW-1:0]  n1, nk, row, rr;
   logic            any_empty;

   link_type        lk_link [NCELLS+1];
   logic [DW-1:0]   lk_val  [NCELLS+1];
   logic [CH_W-1:0] ch_a    [NCELLS+1];
   logic            ch_act  [NCELLS+1];
   logic [DW-1:0]   rowmax  [NCELLS];

   assign l1 = lengths[0];
   assign lk = lengths[k_ff];
   assign n1 = CTW'({l1, 1'b0}) - CTW'(1);
   assign nk = CTW'({lk, 1'b0}) - CTW'(1);

   always_comb begin
      any_empty = 1'b0;
      for (int s = 0; s < MAX_STRINGS; s++) begin
         if (CTW'(s) < CTW'(count) && lengths[s] == '0) begin
            any_empty = 1'b1;
         end
      end
   end

   // Row of string 0 whose character is read this cycle for loading into the chain, last row first.
   always_comb begin
      row = i0_ff + CTW'(NCELLS - 1) - cnt_ff;
      rr  = d1_ff ? (n1 - CTW'(1) - row) : row;
      if (rr >= CTW'(l1)) begin
         rr = rr - CTW'(l1);
      end
   end

   assign upd_i  = DW'(i0_ff + cnt_ff);
   assign rm_sel = rowmax[cnt_ff[CIW-1:0]];
   assign act_sel = ch_act[CAW'(cnt_ff[CIW-1:0]) + CAW'(1)];

   always_comb begin
      nb = rm_sel;
      if (d2_ff && best_rd_ff > rm_sel) begin
         nb = best_rd_ff;
      end
      nm = nb;
      if (k_ff != SW'(1) && min_rd_ff < nb) begin
         nm = min_rd_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      d1_in         = d1_ff;
      d2_in         = d2_ff;
      i0_in         = i0_ff;
      cnt_in        = cnt_ff;
      wq_in         = lk_link[NCELLS].valid ? wq_ff + CTW'(1) : wq_ff;
      pos_in        = pos_ff;
      ph_in         = ph_ff;
      res_in        = res_ff;
      load_vld_in   = 1'b0;
      load_act_in   = 1'b0;
      strm_vld_in   = 1'b0;
      strm_first_in = 1'b0;
      sw_vld_in     = 1'b0;
      char_ra       = {SW'(0), rr[PW-1:0]};
      prev_ra       = cnt_ff[DW-1:0];
      min_ra        = {d1_ff, upd_i};
      bw_en         = 1'b0;
      mw_en         = 1'b0;
      stat.busy     = (state_ff != ST_IDLE);
      stat.done     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            k_in   = SW'(1);
            d1_in  = 1'b0;
            d2_in  = 1'b0;
            i0_in  = '0;
            cnt_in = '0;
            wq_in  = '0;
            if (any_empty) begin
               res_in   = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (cnt_ff < CTW'(NCELLS)) begin
               load_vld_in = 1'b1;
               load_act_in = (row < n1);
               cnt_in      = cnt_ff + CTW'(1);
            end else begin
               cnt_in   = '0;
               pos_in   = '0;
               if (d2_ff && lk >= LENW'(2)) begin
                  pos_in = PW'(lk - LENW'(2));
               end
               state_in = ST_STREAM;
            end
         end
         ST_STREAM: begin
            char_ra = {k_ff, pos_ff};
            if (cnt_ff < nk) begin
               strm_vld_in   = 1'b1;
               strm_first_in = (cnt_ff == '0);
               cnt_in        = cnt_ff + CTW'(1);
               if (!d2_ff) begin
                  pos_in = (LENW'(pos_ff) == lk - LENW'(1)) ? '0 : pos_ff + PW'(1);
               end else begin
                  pos_in = (pos_ff == '0) ? PW'(lk - LENW'(1)) : pos_ff - PW'(1);
               end
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (wq_ff == nk) begin
               cnt_in   = '0;
               ph_in    = 1'b0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (cnt_ff < CTW'(NCELLS)) begin
               if (ph_ff) begin
                  bw_en  = act_sel;
                  mw_en  = act_sel && d2_ff;
                  cnt_in = cnt_ff + CTW'(1);
               end
               ph_in = !ph_ff;
            end else begin
               cnt_in   = '0;
               wq_in    = '0;
               state_in = ST_LOAD;
               if (i0_ff + CTW'(NCELLS) < n1) begin
                  i0_in = i0_ff + CTW'(NCELLS);
               end else begin
                  i0_in = '0;
                  if (!d2_ff) begin
                     d2_in = 1'b1;
                  end else begin
                     d2_in = 1'b0;
                     if (!d1_ff) begin
                        d1_in = 1'b1;
                     end else begin
                        d1_in = 1'b0;
                        if (CNTW'(k_ff) + CNTW'(1) < count) begin
                           k_in = k_ff + SW'(1);
                        end else begin
                           res_in   = '0;
                           state_in = ST_SWEEP;
                        end
                     end
                  end
               end
            end
         end
         ST_SWEEP: begin
            min_ra = {d1_ff, cnt_ff[DW-1:0]};
            if (sw_vld_ff && min_rd_ff > res_ff) begin
               res_in = min_rd_ff;
            end
            if (cnt_ff < n1) begin
               sw_vld_in = 1'b1;
               cnt_in    = cnt_ff + CTW'(1);
            end else if (!d1_ff) begin
               d1_in  = 1'b1;
               cnt_in = '0;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               stat.done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_vld_ff   <= 1'b0;
         strm_vld_ff   <= 1'b0;
         sw_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_vld_ff   <= load_vld_in;
         strm_vld_ff   <= strm_vld_in;
         sw_vld_ff     <= sw_vld_in;
      end
      k_ff          <= k_in;
      d1_ff         <= d1_in;
      d2_ff         <= d2_in;
      i0_ff         <= i0_in;
      cnt_ff        <= cnt_in;
      wq_ff         <= wq_in;
      pos_ff        <= pos_in;
      ph_ff         <= ph_in;
      res_ff        <= res_in;
      load_act_ff   <= load_act_in;
      strm_first_ff <= strm_first_in;
   end

   always_ff @(posedge clock) begin
      if (cw_en) begin
         char_mem[cw_addr] <= cw_data;
      end
      char_rd_ff <= char_mem[char_ra];
   end

   always_ff @(posedge clock) begin
      if (lk_link[NCELLS].valid) begin
         prev_mem[wq_ff[DW-1:0]] <= lk_val[NCELLS];
      end
      prev_rd_ff <= prev_mem[prev_ra];
   end

   always_ff @(posedge clock) begin
      if (bw_en) begin
         best_mem[upd_i] <= nb;
      end
      best_rd_ff <= best_mem[upd_i];
   end

   always_ff @(posedge clock) begin
      if (mw_en) begin
         min_mem[{d1_ff, upd_i}] <= nm;
      end
      min_rd_ff <= min_mem[min_ra];
   end

   // The first row group of a pass sees an all-zero previous row.
   assign lk_link[0].valid = strm_vld_ff;
   assign lk_link[0].first = strm_first_ff;
   assign lk_link[0].b     = char_rd_ff;
   assign lk_val[0]        = (i0_ff == '0) ? '0 : prev_rd_ff;
   assign ch_a[0]          = char_rd_ff;
   assign ch_act[0]        = load_act_ff;

   for (genvar c = 0; c < NCELLS; c++) begin : g_cell
      ccsl_cell #(
         .VW (DW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (load_vld_ff),
         .a_in    (ch_a[c]),
         .act_in  (ch_act[c]),
         .a_out   (ch_a[c+1]),
         .act_out (ch_act[c+1]),
         .lin     (lk_link[c]),
         .vin     (lk_val[c]),
         .lout    (lk_link[c+1]),
         .vout    (lk_val[c+1]),
         .rowmax  (rowmax[c])
      );
   end

   assign result = res_ff;

endmodule
`default_nettype wire

// ===== src/cyclic_common_substring_length.sv =====
// Top level: request intake, string lengths, configuration port and result register.
//
// Requests carry one character each (string_index, ch in tdata; last_of_string in
// tlast). An in-range request is written to the character store while its string has room.
// The request that ends the last string starts the compute pass; req_tready stays low
// until the pass has finished. The pass runs a chain of NCELLS cells over groups of
// NCELLS rows of string 0's doubled form (n0 = 2*L0-1 rows): each group is loaded,
// the other string's doubled form (nk = 2*Lk-1 characters) is streamed through, the
// chain is drained and the group's row maxima are written back; this is done for every
// other string and all four direction pairs, followed by a sweep over the per-row minima.
// One response carrying match_length follows each compute pass; it waits in an output
// register while rsp_tready is low, and a later pass holds its result until it is taken.
// Reset clears the lengths, the done marks, string_count (to 2) and all handshakes.
// The character store is not cleared; entries are only read after they are written.
`default_nettype none
module cyclic_common_substring_length import ccsl_pkg::*; #(
   parameter int MAX_STRINGS = 10,
   parameter int MAX_LEN     = 1024,
   parameter int NCELLS      = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [3:0] string_index, [11:4] ch, rest zero
   input  wire logic        req_tlast,   // last_of_string
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [10:0] match_length, rest zero
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [0:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int SW   = $clog2(MAX_STRINGS);
   localparam int PW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LENW = $clog2(MAX_LEN + 1);
   localparam int DW   = $clog2(2 * MAX_LEN);
   localparam int CNTW = $clog2(MAX_STRINGS + 1);
   localparam int IW   = (CNTW > 4) ? CNTW : 4;

   logic [3:0]      sc_ff;
   logic [LENW-1:0] len_ff [MAX_STRINGS];
   logic            done_ff [MAX_STRINGS];
   logic            rsp_vld_ff;
   logic [OUT_W-1:0] match_ff;

   logic [3:0]      sidx;
   logic [IW-1:0]   eff;
   logic            take, in_range, start;
   logic [SW-1:0]   s;
   logic [LENW-1:0] cur;
   logic            cw_en;
   stat_type        stat;
   logic [DW-1:0]   result;

   assign sidx = req_tdata[3:0];
   assign s    = sidx[SW-1:0];

   always_comb begin
      eff = IW'(sc_ff);
      if (eff < IW'(MIN_STRINGS)) begin
         eff = IW'(MIN_STRINGS);
      end else if (eff > IW'(MAX_STRINGS)) begin
         eff = IW'(MAX_STRINGS);
      end
   end

   assign req_tready = !stat.busy;
   assign take       = req_tvalid && req_tready;
   assign in_range   = IW'(sidx) < eff;
   assign cur        = done_ff[s] ? '0 : len_ff[s];
   assign cw_en      = take && in_range && cur < LENW'(MAX_LEN);
   assign start      = take && in_range && req_tlast && IW'(sidx) == eff - IW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_STRINGS; i++) begin
            len_ff[i]  <= '0;
            done_ff[i] <= 1'b0;
         end
      end else if (take && in_range) begin
         len_ff[s]  <= cw_en ? cur + LENW'(1) : cur;
         done_ff[s] <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff <= 4'(MIN_STRINGS);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == 1'(REG_STRING_COUNT)) begin
         sc_ff <= csr_pwdata[3:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 1'(REG_STRING_COUNT)) ? {28'd0, sc_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (stat.done) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (stat.done) begin
         match_ff <= OUT_W'(result);
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(16 - OUT_W)'(0), match_ff};

   ccsl_engine #(
      .MAX_STRINGS (MAX_STRINGS),
      .NCELLS      (NCELLS),
      .SW          (SW),
      .PW          (PW),
      .LENW        (LENW),
      .DW          (DW),
      .CNTW        (CNTW)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .count    (CNTW'(eff)),
      .lengths  (len_ff),
      .cw_en    (cw_en),
      .cw_addr  ({s, cur[PW-1:0]}),
      .cw_data  (req_tdata[11:4]),
      .out_free (!rsp_vld_ff),
      .stat     (stat),
      .result   (result)
   );

endmodule
`default_nettype wire

// ===== verif/ccsl_checker.sv =====
// Checker for the cyclic common substring length block: predicts and compares responses.
`default_nettype none
module ccsl_checker import ccsl_pkg::*; #(
   parameter int MAX_STRINGS = 10,
   parameter int MAX_LEN     = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [0:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DBL = 2 * MAX_LEN;
   localparam logic [OUT_W-1:0] LEN_ONES = '1;

   logic [CH_W-1:0]  chars [MAX_STRINGS][MAX_LEN];
   int               str_len [MAX_STRINGS];
   bit               str_closed [MAX_STRINGS];
   logic [3:0]       count_reg;
   logic [OUT_W-1:0] expected_lengths [$];

   int prev_row [DBL+1];
   int best_end [DBL];
   int min_len [2][DBL];

   assign pending = expected_lengths.size();

   function automatic logic [CH_W-1:0] doubled_char(int s, int p, int n, bit rev);
      int q;
      q = rev ? (2 * n - 2 - p) : p;
      if (q >= n) q -= n;
      return chars[s][q];
   endfunction

   // Longest run ending in string 0 (either direction) that every other string holds.
   function logic [OUT_W-1:0] common_length(int count);
      int l0, n0, lk, nk, v, res;
      logic [CH_W-1:0] a;
      l0 = str_len[0];
      res = 0;
      if (l0 == 0) return '0;
      n0 = 2 * l0 - 1;
      for (int d = 0; d < 2; d++)
         for (int i = 0; i < n0; i++) min_len[d][i] = LEN_ONES;
      for (int k = 1; k < count; k++) begin
         lk = str_len[k];
         nk = (lk != 0) ? 2 * lk - 1 : 0;
         for (int d1 = 0; d1 < 2; d1++) begin
            for (int i = 0; i < n0; i++) best_end[i] = 0;
            for (int d2 = 0; d2 < 2 && nk > 0; d2++) begin
               for (int j = 0; j <= nk; j++) prev_row[j] = 0;
               for (int i = 0; i < n0; i++) begin
                  a = doubled_char(0, i, l0, d1);
                  for (int j = nk; j >= 1; j--) begin
                     v = (doubled_char(k, j - 1, lk, d2) == a) ? prev_row[j-1] + 1 : 0;
                     prev_row[j] = v;
                     if (v > best_end[i]) best_end[i] = v;
                  end
               end
            end
            for (int i = 0; i < n0; i++)
               if (best_end[i] < min_len[d1][i]) min_len[d1][i] = best_end[i];
         end
      end
      for (int d = 0; d < 2; d++)
         for (int i = 0; i < n0; i++)
            if (min_len[d][i] > res) res = min_len[d][i];
      return res[OUT_W-1:0];
   endfunction

   always @(posedge clock) begin
      int idx, eff;
      logic [OUT_W-1:0] want;
      if (reset) begin
         for (int s = 0; s < MAX_STRINGS; s++) begin
            str_len[s] = 0;
            str_closed[s] = 0;
         end
         count_reg = 4'd2;
         expected_lengths.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_lengths.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d",
                        $time, rsp_tdata[OUT_W-1:0]);
               fail_count++;
            end else begin
               want = expected_lengths.pop_front();
               if (rsp_tdata != {5'd0, want}) begin
                  $display("%0t: match_length mismatch, expected %0d, actual %0d (tdata %h)",
                           $time, want, rsp_tdata[OUT_W-1:0], rsp_tdata);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            idx = req_tdata[3:0];
            eff = (count_reg < MIN_STRINGS) ? MIN_STRINGS :
                  (count_reg > MAX_STRINGS) ? MAX_STRINGS : count_reg;
            if (idx < eff) begin
               if (str_closed[idx]) begin
                  str_closed[idx] = 0;
                  str_len[idx] = 0;
               end
               if (str_len[idx] < MAX_LEN) begin
                  chars[idx][str_len[idx]] = req_tdata[11:4];
                  str_len[idx]++;
               end
               if (req_tlast) begin
                  str_closed[idx] = 1;
                  if (idx == eff - 1) expected_lengths.push_back(common_length(eff));
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == REG_STRING_COUNT)
            count_reg = csr_pwdata[3:0];
      end
   end
endmodule
`default_nettype wire

// ===== verif/tb_cyclic_common_substring_length.sv =====
// Testbench top: clock, reset, request and register stimulus, and the final verdict.
`default_nettype none
module tb_cyclic_common_substring_length import ccsl_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 6000000;
   localparam int TARGET_REQUESTS = 1600;
   localparam int MAX_LEN_TB = 1024;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tlast;
   logic [15:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [0:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   int          fail_count, pending, cycles, sent;
   logic        req_took;
   bit          calm;

   cyclic_common_substring_length dut (.*);

   ccsl_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      req_took <= req_tvalid && req_tready;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side stalls in bursts until the calm tail of the run.
   initial begin
      rsp_tready = 1;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_tready <= 1;
         end
      end
   end

   task automatic send(input int idx, input logic [7:0] c, input bit last_ch);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tdata  <= {4'd0, c, idx[3:0]};
      req_tlast  <= last_ch;
      req_tvalid <= 1;
      do @(negedge clock); while (!req_took);
      sent++;
   endtask

   // Waits until every response is back and the block has gone quiet.
   task automatic drain();
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_count(input logic [3:0] value);
      csr_psel    <= 1;
      csr_pwrite  <= 1;
      csr_penable <= 0;
      csr_paddr   <= 1'(REG_STRING_COUNT);
      csr_pwdata  <= {$urandom_range(0, 1) ? 28'hFFFFFFF : 28'h0, value};
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
   endtask

   function automatic logic [7:0] pick_char(int alphabet);
      return (alphabet == 0) ? 8'($urandom) : 8'(8'h41 + $urandom_range(0, alphabet - 1));
   endfunction

   task automatic send_string(input int idx, input int len, input int alphabet);
      for (int i = 0; i < len; i++) send(idx, pick_char(alphabet), i == len - 1);
   endtask

   // One set of strings ending with the string that triggers the computation.
   task automatic send_set(input int eff, input int max_len);
      int alphabet;
      alphabet = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
      for (int s = 0; s < eff - 1; s++) begin
         if ($urandom_range(0, 9) == 0) send($urandom_range(eff, 15), 8'($urandom), $urandom);
         if ($urandom_range(0, 15) == 0)
            send(s, pick_char(alphabet), 0);  // unfinished, continued below
         send_string(s, $urandom_range(1, max_len), alphabet);
      end
      send_string(eff - 1, $urandom_range(1, max_len), alphabet);
   endtask

   initial begin
      logic [3:0] setting;
      int eff;
      cycles = 0;
      sent = 0;
      calm = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tlast = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: string 0 still empty, then extreme characters and out-of-range index.
      send(1, 8'h41, 1);
      send(0, 8'h00, 0);
      send(0, 8'hFF, 1);
      send(15, 8'h5A, 1);
      send(1, 8'hFF, 0);
      send(1, 8'h00, 1);
      drain();
      write_count(4'd0);
      send(0, 8'h12, 1);
      send(1, 8'h34, 1);
      drain();
      write_count(4'd15);
      for (int s = 0; s < 10; s++) send(s, 8'h77, s == 9);
      drain();
      write_count(4'd1);
      send(0, 8'h61, 0);
      send(0, 8'h62, 1);
      send(1, 8'h62, 0);
      send(1, 8'h61, 1);
      drain();

      // A string longer than the store holds; string 0 stays short to keep the pass quick.
      write_count(4'd2);
      send(0, 8'h41, 1);
      send_string(1, MAX_LEN_TB + 6, 2);
      drain();

      while (sent < TARGET_REQUESTS) begin
         case ($urandom_range(0, 5))
            0: setting = 4'd2;
            1: setting = 4'd10;
            2: setting = 4'($urandom_range(11, 15));
            3: setting = 4'($urandom_range(0, 1));
            default: setting = 4'($urandom_range(3, 9));
         endcase
         eff = (setting < 2) ? 2 : (setting > 10) ? 10 : setting;
         if (sent > TARGET_REQUESTS - 250) calm = 1;
         write_count(setting);
         repeat ($urandom_range(2, 6)) begin
            send_set(eff, ($urandom_range(0, 19) == 0) ? 24 : 6);
            if ($urandom_range(0, 3) == 0) drain();
         end
         drain();
      end

      drain();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== cyclic_common_substring_length.f =====
src/ccsl_pkg.sv
src/ccsl_cell.sv
src/ccsl_engine.sv
src/cyclic_common_substring_length.sv
verif/ccsl_checker.sv
verif/tb_cyclic_common_substring_length.sv
